// ===== hdl/gre_pkg.sv =====
// Shared types, sizes and helpers for the graph reachability engine.
// Used by gre_ctrl, gre_datapath and graph_reachability_engine; no dependencies.
package gre_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_DEGREE   = 64;

  localparam int VERT_W  = 7;
  localparam int MODE_W  = 3;
  localparam int MARK_W  = 2;
  localparam int STAT_W  = 2;
  localparam int EDGE_W  = 12;
  localparam int VIDX_W  = $clog2(MAX_VERTICES);
  localparam int DIDX_W  = $clog2(MAX_DEGREE);
  localparam int LEN_W   = $clog2(MAX_DEGREE + 1);
  localparam int SP_W    = $clog2(MAX_VERTICES + 1);
  localparam int ADDR_W  = VIDX_W + DIDX_W;
  localparam int FRAME_W = VERT_W + LEN_W;

  localparam logic [EDGE_W-1:0] EDGE_LIMIT = '1;

  localparam logic [MARK_W-1:0] MARK_UNVISITED  = 2'd0;
  localparam logic [MARK_W-1:0] MARK_INPROGRESS = 2'd1;
  localparam logic [MARK_W-1:0] MARK_ALLDONE    = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ILLEGAL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

  localparam logic [VERT_W-1:0] VCOUNT_RESET = 7'd64;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD   = 3'd0,
    MODE_CLEAR = 3'd1,
    MODE_SET   = 3'd2,
    MODE_READ  = 3'd3,
    MODE_COUNT = 3'd4,
    MODE_PATH  = 3'd5
  } mode_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_ADD_LU, S_ADD_LV, S_ADD_SCAN, S_ADD_CMP, S_ADD_W2,
    S_OK, S_MARK_OUT, S_COUNT_OUT, S_W_LEN, S_W_LENQ, S_W_SCAN, S_W_NB,
    S_W_MARK, S_W_POP
  } state_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_LOAD, DP_RD_LEN_A, DP_RD_LEN_B, DP_CAP_LEN_V, DP_RD_SCAN,
    DP_WRITE_1, DP_WRITE_2, DP_CLEAR_MARKS, DP_SET_MARK, DP_RD_MARK_A,
    DP_WALK_INIT, DP_RD_LEN_X, DP_CAP_LEN_X, DP_RD_NB, DP_RD_MARK_Y,
    DP_PUSH, DP_POP, DP_LOAD_TOP, DP_RES_OK, DP_RES_ILLEGAL, DP_RES_FULL,
    DP_RES_FOUND, DP_RES_MARK, DP_RES_COUNT
  } dp_op_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic a_ok;
    logic b_ok;
    logic same;
    logic scan_more;
    logic nb_match;
    logic room;
    logic walk_more;
    logic y_ok;
    logic mark_zero;
    logic y_dst;
    logic stack_full;
    logic sp_last;
  } dp_status_t;

  function automatic logic vertex_ok(input logic [VERT_W-1:0] v,
                                     input logic [VERT_W-1:0] vc);
    logic [VERT_W:0] ord;
    ord = ({1'b0, vc} > (VERT_W+1)'(MAX_VERTICES)) ? (VERT_W+1)'(MAX_VERTICES)
                                                   : {1'b0, vc};
    return (v != '0) && ({1'b0, v} <= ord);
  endfunction

endpackage

// ===== hdl/graph_reachability_engine.sv =====
// Top level of the graph reachability engine: controller plus datapath.
// Depends on gre_pkg, gre_ctrl and gre_datapath.
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------------
//  command | start, busy        | mode, vertex_a, vertex_b, mark_value
//  result  | done (one cycle)   | status, path_found, mark_out, neighbor_count, edge_total
//  config  | cfg_write          | cfg_data (vertex_count)
//
// One word at a time. Add edge scans the list of vertex_a entry by entry, and
// a path query reads the neighbour entries of each vertex it enters in turn:
// reads of the neighbour store set the pace.
// Synchronous reset clears marks, list lengths and the edge total at once.
// done is a one-cycle strobe; the receiver cannot stall it.
module graph_reachability_engine (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [gre_pkg::MODE_W-1:0]         mode,
  input  logic [gre_pkg::VERT_W-1:0]         vertex_a,
  input  logic [gre_pkg::VERT_W-1:0]         vertex_b,
  input  logic [gre_pkg::MARK_W-1:0]         mark_value,
  input  logic                               cfg_write,
  input  logic [gre_pkg::VERT_W-1:0]         cfg_data,
  output logic                               done,
  output logic [gre_pkg::STAT_W-1:0]         status,
  output logic                               path_found,
  output logic [gre_pkg::MARK_W-1:0]         mark_out,
  output logic [gre_pkg::LEN_W-1:0]          neighbor_count,
  output logic [gre_pkg::EDGE_W-1:0]         edge_total
);

  gre_pkg::dp_op_t     op;
  gre_pkg::dp_status_t st;

  gre_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .op    (op),
    .busy  (busy)
  );

  gre_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .op             (op),
    .st             (st),
    .mode           (mode),
    .vertex_a       (vertex_a),
    .vertex_b       (vertex_b),
    .mark_value     (mark_value),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .done           (done),
    .status         (status),
    .path_found     (path_found),
    .mark_out       (mark_out),
    .neighbor_count (neighbor_count),
    .edge_total     (edge_total)
  );

endmodule

// ===== hdl/gre_ctrl.sv =====
// Sequencer for the graph reachability engine: one state machine, one word at a time.
// Depends on gre_pkg; drives gre_datapath through dp_op_t and reads dp_status_t.
module gre_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  gre_pkg::dp_status_t st,
  output gre_pkg::dp_op_t     op,
  output logic                busy
);

  gre_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gre_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != gre_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      gre_pkg::S_IDLE: begin
        if (start) state_next = gre_pkg::S_DECODE;
      end
      gre_pkg::S_DECODE: begin
        unique case (st.mode)
          gre_pkg::MODE_ADD:   state_next = (st.a_ok && st.b_ok) ? gre_pkg::S_ADD_LU
                                                                  : gre_pkg::S_IDLE;
          gre_pkg::MODE_CLEAR: state_next = gre_pkg::S_OK;
          gre_pkg::MODE_SET:   state_next = st.a_ok ? gre_pkg::S_OK : gre_pkg::S_IDLE;
          gre_pkg::MODE_READ:  state_next = st.a_ok ? gre_pkg::S_MARK_OUT : gre_pkg::S_IDLE;
          gre_pkg::MODE_COUNT: state_next = st.a_ok ? gre_pkg::S_COUNT_OUT : gre_pkg::S_IDLE;
          gre_pkg::MODE_PATH:  state_next = (st.a_ok && st.b_ok && !st.same) ?
                                            gre_pkg::S_W_LEN : gre_pkg::S_IDLE;
          default:             state_next = gre_pkg::S_IDLE;
        endcase
      end
      gre_pkg::S_ADD_LU:    state_next = gre_pkg::S_ADD_LV;
      gre_pkg::S_ADD_LV:    state_next = gre_pkg::S_ADD_SCAN;
      gre_pkg::S_ADD_SCAN: begin
        if (st.scan_more)  state_next = gre_pkg::S_ADD_CMP;
        else if (!st.room) state_next = gre_pkg::S_IDLE;
        else               state_next = gre_pkg::S_ADD_W2;
      end
      gre_pkg::S_ADD_CMP:   state_next = st.nb_match ? gre_pkg::S_IDLE : gre_pkg::S_ADD_SCAN;
      gre_pkg::S_ADD_W2:    state_next = gre_pkg::S_OK;
      gre_pkg::S_OK:        state_next = gre_pkg::S_IDLE;
      gre_pkg::S_MARK_OUT:  state_next = gre_pkg::S_IDLE;
      gre_pkg::S_COUNT_OUT: state_next = gre_pkg::S_IDLE;
      gre_pkg::S_W_LEN:     state_next = gre_pkg::S_W_LENQ;
      gre_pkg::S_W_LENQ:    state_next = gre_pkg::S_W_SCAN;
      gre_pkg::S_W_SCAN: begin
        if (st.walk_more)    state_next = gre_pkg::S_W_NB;
        else if (st.sp_last) state_next = gre_pkg::S_OK;
        else                 state_next = gre_pkg::S_W_POP;
      end
      gre_pkg::S_W_NB:      state_next = st.y_ok ? gre_pkg::S_W_MARK : gre_pkg::S_W_SCAN;
      gre_pkg::S_W_MARK: begin
        if (!st.mark_zero)     state_next = gre_pkg::S_W_SCAN;
        else if (st.y_dst)     state_next = gre_pkg::S_IDLE;
        else if (st.stack_full) state_next = gre_pkg::S_W_SCAN;
        else                   state_next = gre_pkg::S_W_LEN;
      end
      gre_pkg::S_W_POP:     state_next = gre_pkg::S_W_LEN;
      default:              state_next = gre_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op = gre_pkg::DP_NOP;
    unique case (state)
      gre_pkg::S_IDLE: begin
        if (start) op = gre_pkg::DP_LOAD;
      end
      gre_pkg::S_DECODE: begin
        unique case (st.mode)
          gre_pkg::MODE_ADD:   op = (st.a_ok && st.b_ok) ? gre_pkg::DP_RD_LEN_A
                                                          : gre_pkg::DP_RES_ILLEGAL;
          gre_pkg::MODE_CLEAR: op = gre_pkg::DP_CLEAR_MARKS;
          gre_pkg::MODE_SET:   op = st.a_ok ? gre_pkg::DP_SET_MARK : gre_pkg::DP_RES_ILLEGAL;
          gre_pkg::MODE_READ:  op = st.a_ok ? gre_pkg::DP_RD_MARK_A : gre_pkg::DP_RES_ILLEGAL;
          gre_pkg::MODE_COUNT: op = st.a_ok ? gre_pkg::DP_RD_LEN_A : gre_pkg::DP_RES_ILLEGAL;
          gre_pkg::MODE_PATH: begin
            if (!(st.a_ok && st.b_ok)) op = gre_pkg::DP_RES_ILLEGAL;
            else if (st.same)          op = gre_pkg::DP_RES_FOUND;
            else                       op = gre_pkg::DP_WALK_INIT;
          end
          default:             op = gre_pkg::DP_RES_OK;
        endcase
      end
      gre_pkg::S_ADD_LU:    op = gre_pkg::DP_RD_LEN_B;
      gre_pkg::S_ADD_LV:    op = gre_pkg::DP_CAP_LEN_V;
      gre_pkg::S_ADD_SCAN: begin
        if (st.scan_more)  op = gre_pkg::DP_RD_SCAN;
        else if (!st.room) op = gre_pkg::DP_RES_FULL;
        else               op = gre_pkg::DP_WRITE_1;
      end
      gre_pkg::S_ADD_CMP:   op = st.nb_match ? gre_pkg::DP_RES_OK : gre_pkg::DP_NOP;
      gre_pkg::S_ADD_W2:    op = gre_pkg::DP_WRITE_2;
      gre_pkg::S_OK:        op = gre_pkg::DP_RES_OK;
      gre_pkg::S_MARK_OUT:  op = gre_pkg::DP_RES_MARK;
      gre_pkg::S_COUNT_OUT: op = gre_pkg::DP_RES_COUNT;
      gre_pkg::S_W_LEN:     op = gre_pkg::DP_RD_LEN_X;
      gre_pkg::S_W_LENQ:    op = gre_pkg::DP_CAP_LEN_X;
      gre_pkg::S_W_SCAN:    op = st.walk_more ? gre_pkg::DP_RD_NB : gre_pkg::DP_POP;
      gre_pkg::S_W_NB:      op = st.y_ok ? gre_pkg::DP_RD_MARK_Y : gre_pkg::DP_NOP;
      gre_pkg::S_W_MARK: begin
        if (!st.mark_zero)      op = gre_pkg::DP_NOP;
        else if (st.y_dst)      op = gre_pkg::DP_RES_FOUND;
        else if (st.stack_full) op = gre_pkg::DP_NOP;
        else                    op = gre_pkg::DP_PUSH;
      end
      gre_pkg::S_W_POP:     op = gre_pkg::DP_LOAD_TOP;
      default:              op = gre_pkg::DP_NOP;
    endcase
  end

endmodule

// ===== hdl/gre_datapath.sv =====
// Datapath of the graph reachability engine: neighbour store, list lengths,
// marks, walk stack, working registers and result registers. Depends on gre_pkg.
module gre_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  gre_pkg::dp_op_t                    op,
  output gre_pkg::dp_status_t                st,
  input  logic [gre_pkg::MODE_W-1:0]         mode,
  input  logic [gre_pkg::VERT_W-1:0]         vertex_a,
  input  logic [gre_pkg::VERT_W-1:0]         vertex_b,
  input  logic [gre_pkg::MARK_W-1:0]         mark_value,
  input  logic                               cfg_write,
  input  logic [gre_pkg::VERT_W-1:0]         cfg_data,
  output logic                               done,
  output logic [gre_pkg::STAT_W-1:0]         status,
  output logic                               path_found,
  output logic [gre_pkg::MARK_W-1:0]         mark_out,
  output logic [gre_pkg::LEN_W-1:0]          neighbor_count,
  output logic [gre_pkg::EDGE_W-1:0]         edge_total
);

  logic [gre_pkg::VERT_W-1:0]  store [2**gre_pkg::ADDR_W];
  logic [gre_pkg::LEN_W-1:0]   len_mem [gre_pkg::MAX_VERTICES];
  logic [gre_pkg::MAX_VERTICES-1:0] len_valid;
  logic [gre_pkg::MARK_W-1:0]  mark_mem [gre_pkg::MAX_VERTICES];
  logic [gre_pkg::MAX_VERTICES-1:0] mark_valid;
  logic [gre_pkg::FRAME_W-1:0] stack [gre_pkg::MAX_VERTICES];

  logic [gre_pkg::MODE_W-1:0]  md;
  logic [gre_pkg::VERT_W-1:0]  a, b, vcount, x;
  logic [gre_pkg::MARK_W-1:0]  mv;
  logic [gre_pkg::EDGE_W-1:0]  edges;
  logic [gre_pkg::LEN_W-1:0]   len_u, len_v, i, pos, curlen;
  logic [gre_pkg::SP_W-1:0]    sp;
  logic [gre_pkg::VERT_W-1:0]  nb_q;
  logic [gre_pkg::LEN_W-1:0]   len_q;
  logic                        len_vq;
  logic [gre_pkg::MARK_W-1:0]  mark_q;
  logic                        mark_vq;
  logic [gre_pkg::FRAME_W-1:0] stk_q;

  logic [gre_pkg::LEN_W-1:0]   len_rd, wpos;
  logic [gre_pkg::MARK_W-1:0]  mark_rd;
  logic [gre_pkg::VIDX_W-1:0]  ia, ib, ix, iy;
  logic [gre_pkg::VERT_W-1:0]  am1, bm1, xm1, ym1;
  logic [gre_pkg::SP_W-1:0]    sp_m1, sp_m2;

  logic                        st_we, st_re, len_we, len_re, mark_we, mark_re, mark_clr;
  logic                        stk_we, stk_re;
  logic [gre_pkg::ADDR_W-1:0]  st_wa, st_ra;
  logic [gre_pkg::VERT_W-1:0]  st_wd;
  logic [gre_pkg::VIDX_W-1:0]  len_wa, len_ra, mark_wa, mark_ra, stk_wa, stk_ra;
  logic [gre_pkg::LEN_W-1:0]   len_wd;
  logic [gre_pkg::MARK_W-1:0]  mark_wd;
  logic [gre_pkg::FRAME_W-1:0] stk_wd;

  assign am1   = a - 1'b1;
  assign bm1   = b - 1'b1;
  assign xm1   = x - 1'b1;
  assign ym1   = nb_q - 1'b1;
  assign ia    = am1[gre_pkg::VIDX_W-1:0];
  assign ib    = bm1[gre_pkg::VIDX_W-1:0];
  assign ix    = xm1[gre_pkg::VIDX_W-1:0];
  assign iy    = ym1[gre_pkg::VIDX_W-1:0];
  assign sp_m1 = sp - 1'b1;
  assign sp_m2 = sp - 2'd2;
  assign len_rd  = len_vq ? len_q : '0;
  assign mark_rd = mark_vq ? mark_q : gre_pkg::MARK_UNVISITED;
  assign wpos    = (a == b) ? len_u + 1'b1 : len_v;

  always_comb begin
    st.mode       = md;
    st.a_ok       = gre_pkg::vertex_ok(a, vcount);
    st.b_ok       = gre_pkg::vertex_ok(b, vcount);
    st.same       = (a == b);
    st.scan_more  = (i < len_u);
    st.nb_match   = (nb_q == b);
    st.room       = (a == b) ?
                    ({1'b0, len_u} + 2'd2 <= (gre_pkg::LEN_W+1)'(gre_pkg::MAX_DEGREE)) :
                    ((len_u < gre_pkg::LEN_W'(gre_pkg::MAX_DEGREE)) &&
                     (len_v < gre_pkg::LEN_W'(gre_pkg::MAX_DEGREE)));
    st.walk_more  = (pos < curlen);
    st.y_ok       = gre_pkg::vertex_ok(nb_q, vcount);
    st.mark_zero  = (mark_rd == gre_pkg::MARK_UNVISITED);
    st.y_dst      = (nb_q == b);
    st.stack_full = (sp >= gre_pkg::SP_W'(gre_pkg::MAX_VERTICES));
    st.sp_last    = (sp == gre_pkg::SP_W'(1));
  end

  always_comb begin
    st_we = 1'b0; st_re = 1'b0; len_we = 1'b0; len_re = 1'b0;
    mark_we = 1'b0; mark_re = 1'b0; mark_clr = 1'b0; stk_we = 1'b0; stk_re = 1'b0;
    st_wa  = {ia, len_u[gre_pkg::DIDX_W-1:0]};
    st_ra  = {ia, i[gre_pkg::DIDX_W-1:0]};
    st_wd  = b;
    len_wa = ia; len_ra = ia; len_wd = len_u + 1'b1;
    mark_wa = ia; mark_ra = ia; mark_wd = mv;
    stk_wa = sp_m1[gre_pkg::VIDX_W-1:0];
    stk_ra = sp_m2[gre_pkg::VIDX_W-1:0];
    stk_wd = {x, pos};
    unique case (op)
      gre_pkg::DP_RD_LEN_A:    len_re = 1'b1;
      gre_pkg::DP_RD_LEN_B: begin
        len_re = 1'b1; len_ra = ib;
      end
      gre_pkg::DP_RD_SCAN:     st_re = 1'b1;
      gre_pkg::DP_WRITE_1: begin
        st_we = 1'b1; len_we = 1'b1;
      end
      gre_pkg::DP_WRITE_2: begin
        st_we = 1'b1; st_wa = {ib, wpos[gre_pkg::DIDX_W-1:0]}; st_wd = a;
        len_we = 1'b1; len_wa = ib; len_wd = wpos + 1'b1;
      end
      gre_pkg::DP_CLEAR_MARKS: mark_clr = 1'b1;
      gre_pkg::DP_SET_MARK:    mark_we = 1'b1;
      gre_pkg::DP_RD_MARK_A:   mark_re = 1'b1;
      gre_pkg::DP_WALK_INIT: begin
        mark_we = 1'b1; mark_wd = gre_pkg::MARK_INPROGRESS;
      end
      gre_pkg::DP_RD_LEN_X: begin
        len_re = 1'b1; len_ra = ix;
      end
      gre_pkg::DP_RD_NB: begin
        st_re = 1'b1; st_ra = {ix, pos[gre_pkg::DIDX_W-1:0]};
      end
      gre_pkg::DP_RD_MARK_Y: begin
        mark_re = 1'b1; mark_ra = iy;
      end
      gre_pkg::DP_PUSH: begin
        stk_we = 1'b1;
        mark_we = 1'b1; mark_wa = iy; mark_wd = gre_pkg::MARK_INPROGRESS;
      end
      gre_pkg::DP_POP: begin
        stk_re = 1'b1;
        mark_we = 1'b1; mark_wa = ix; mark_wd = gre_pkg::MARK_ALLDONE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) store[st_wa] <= st_wd;
    if (st_re) nb_q <= store[st_ra];
    if (len_we) len_mem[len_wa] <= len_wd;
    if (len_re) len_q <= len_mem[len_ra];
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    if (mark_re) mark_q <= mark_mem[mark_ra];
    if (stk_we) stack[stk_wa] <= stk_wd;
    if (stk_re) stk_q <= stack[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_valid  <= '0;
      mark_valid <= '0;
      len_vq     <= 1'b0;
      mark_vq    <= 1'b0;
    end else begin
      if (len_we) len_valid[len_wa] <= 1'b1;
      if (len_re) len_vq <= len_valid[len_ra];
      if (mark_clr) mark_valid <= '0;
      else if (mark_we) mark_valid[mark_wa] <= 1'b1;
      if (mark_re) mark_vq <= mark_valid[mark_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= gre_pkg::VCOUNT_RESET;
      edges  <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write) vcount <= cfg_data;
      unique case (op)
        gre_pkg::DP_WRITE_2: begin
          if (edges != gre_pkg::EDGE_LIMIT) edges <= edges + 1'b1;
        end
        gre_pkg::DP_RES_OK, gre_pkg::DP_RES_ILLEGAL, gre_pkg::DP_RES_FULL,
        gre_pkg::DP_RES_FOUND, gre_pkg::DP_RES_MARK, gre_pkg::DP_RES_COUNT:
          done <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      gre_pkg::DP_LOAD: begin
        md <= mode; a <= vertex_a; b <= vertex_b; mv <= mark_value;
      end
      gre_pkg::DP_RD_LEN_B:  len_u <= len_rd;
      gre_pkg::DP_CAP_LEN_V: begin
        len_v <= len_rd; i <= '0;
      end
      gre_pkg::DP_RD_SCAN:   i <= i + 1'b1;
      gre_pkg::DP_WALK_INIT: begin
        x <= a; pos <= '0; sp <= gre_pkg::SP_W'(1);
      end
      gre_pkg::DP_CAP_LEN_X: curlen <= len_rd;
      gre_pkg::DP_RD_NB:     pos <= pos + 1'b1;
      gre_pkg::DP_PUSH: begin
        x <= nb_q; pos <= '0; sp <= sp + 1'b1;
      end
      gre_pkg::DP_POP:       sp <= sp_m1;
      gre_pkg::DP_LOAD_TOP:  {x, pos} <= stk_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (op)
      gre_pkg::DP_RES_OK, gre_pkg::DP_RES_ILLEGAL, gre_pkg::DP_RES_FULL,
      gre_pkg::DP_RES_FOUND, gre_pkg::DP_RES_MARK, gre_pkg::DP_RES_COUNT: begin
        status         <= (op == gre_pkg::DP_RES_ILLEGAL) ? gre_pkg::STAT_ILLEGAL :
                          (op == gre_pkg::DP_RES_FULL)    ? gre_pkg::STAT_FULL :
                                                            gre_pkg::STAT_OK;
        path_found     <= (op == gre_pkg::DP_RES_FOUND);
        mark_out       <= (op == gre_pkg::DP_RES_MARK) ? mark_rd : gre_pkg::MARK_UNVISITED;
        neighbor_count <= (op == gre_pkg::DP_RES_COUNT) ? len_rd : '0;
        edge_total     <= edges;
      end
      default: ;
    endcase
  end

endmodule
